// ===== hdl/prq_pkg.sv =====
// Shared types and codes for the priority ready queue.
// Used by prq_cell, priority_ready_queue and the testbench; depends on nothing.
package prq_pkg;

  localparam logic OP_ACTIVATE  = 1'b0;
  localparam logic OP_TERMINATE = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_QUEUED  = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [3:0] task_id;
    logic [7:0] prio;
  } slot_t;

  typedef struct packed {
    logic [3:0] task_id;
    logic [7:0] prio;
  } cmd_t;

endpackage

// ===== hdl/prq_cell.sv =====
// One slot of the sorted ready queue chain.
// Depends on prq_pkg for the slot and command types.
module prq_cell (
  input  logic           clk,
  input  logic           rst,
  input  prq_pkg::cmd_t  cmd,
  input  logic           insert_en,
  input  logic           remove_en,
  input  prq_pkg::slot_t left_slot,
  input  logic           left_flag,
  input  prq_pkg::slot_t right_slot,
  input  logic           hit_in,
  output prq_pkg::slot_t slot,
  output prq_pkg::slot_t slot_next,
  output logic           ins_flag,
  output logic           hit_out
);

  logic match;

  // A new task goes in front of an empty slot or one of strictly lower priority.
  assign ins_flag = !slot.valid || (cmd.prio > slot.prio);
  assign match    = slot.valid && (slot.task_id == cmd.task_id);
  assign hit_out  = hit_in | match;

  always_comb begin
    slot_next = slot;
    if (insert_en && ins_flag) begin
      if (left_flag) begin
        slot_next = left_slot;
      end else begin
        slot_next.valid   = 1'b1;
        slot_next.task_id = cmd.task_id;
        slot_next.prio    = cmd.prio;
      end
    end else if (remove_en && hit_out) begin
      slot_next = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

// ===== hdl/priority_ready_queue.sv =====
// Top level of the priority ready queue: input capture, cell chain and result register.
// Depends on prq_pkg and prq_cell.
// An accepted word is captured, then executed in the execute state once the output is free,
// and its result word is registered as it executes. A new word is accepted only in the idle state.
// Reset clears the queue to empty and the control and output valid flags.
// The result word may wait on the output while the next word is accepted.
module priority_ready_queue #(
  parameter int TASK_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // task_index[3:0], task_priority[11:4], zero pad
  input  logic        s_tuser,  // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // head_task[3:0], head_valid[4], ready_count[9:5],
                                // status[11:10], zero pad
);

  localparam int CW = $clog2(TASK_COUNT + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic [0:0]     state;
  logic           op;
  prq_pkg::cmd_t  cmd;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic           proceed;
  logic           found;
  logic           out_of_range;
  logic           full;
  logic           insert_en;
  logic           remove_en;
  logic [1:0]     status;
  logic           order_ok;

  prq_pkg::slot_t slot_q    [TASK_COUNT];
  prq_pkg::slot_t slot_n    [TASK_COUNT];
  logic           ins_flag  [TASK_COUNT];
  logic           hit       [TASK_COUNT];

  assign s_tready = (state == ST_IDLE);
  assign proceed  = (state == ST_EXEC) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (proceed) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op          <= s_tuser;
      cmd.task_id <= s_tdata[3:0];
      cmd.prio    <= s_tdata[11:4];
    end
  end

  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    prq_pkg::slot_t left_slot;
    prq_pkg::slot_t right_slot;
    logic           left_flag;
    logic           hit_in;

    if (i == 0) begin : g_first
      assign left_slot = '0;
      assign left_flag = 1'b0;
      assign hit_in    = 1'b0;
    end else begin : g_inner
      assign left_slot = slot_q[i-1];
      assign left_flag = ins_flag[i-1];
      assign hit_in    = hit[i-1];
    end

    if (i == TASK_COUNT - 1) begin : g_last
      assign right_slot = '0;
    end else begin : g_mid
      assign right_slot = slot_q[i+1];
    end

    prq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .insert_en  (insert_en),
      .remove_en  (remove_en),
      .left_slot  (left_slot),
      .left_flag  (left_flag),
      .right_slot (right_slot),
      .hit_in     (hit_in),
      .slot       (slot_q[i]),
      .slot_next  (slot_n[i]),
      .ins_flag   (ins_flag[i]),
      .hit_out    (hit[i])
    );
  end

  assign found        = hit[TASK_COUNT-1];
  assign out_of_range = (32'(cmd.task_id) >= TASK_COUNT);
  assign full         = (count == CW'(TASK_COUNT));

  always_comb begin
    insert_en  = 1'b0;
    remove_en  = 1'b0;
    count_next = count;
    if (op == prq_pkg::OP_ACTIVATE) begin
      status = prq_pkg::STATUS_QUEUED;
      if (!out_of_range && !found && !full) begin
        status     = prq_pkg::STATUS_OK;
        insert_en  = proceed;
        count_next = count + CW'(1);
      end
    end else begin
      status = prq_pkg::STATUS_MISSING;
      if (!out_of_range && found) begin
        status     = prq_pkg::STATUS_OK;
        remove_en  = proceed;
        count_next = count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (proceed) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proceed) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      m_tdata <= {4'd0, status, 5'(count_next), slot_n[0].valid,
                  slot_n[0].valid ? slot_n[0].task_id : 4'd0};
    end
  end

  always_comb begin
    order_ok = 1'b1;
    for (int i = 1; i < TASK_COUNT; i++) begin
      if (slot_q[i].valid &&
          (!slot_q[i-1].valid || (slot_q[i-1].prio < slot_q[i].prio))) begin
        order_ok = 1'b0;
      end
    end
  end

  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    slot_q[0].valid == (count != '0))
    else $error("head slot valid disagrees with queue count");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TASK_COUNT))
    else $error("queue count beyond capacity");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    order_ok)
    else $error("cell chain not sorted by priority");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_EXEC))
    else $error("accepted word did not start execution");

  a_single_update: assert property (@(posedge clk) disable iff (rst)
    !(insert_en && remove_en))
    else $error("insert and remove in the same cycle");

endmodule

// ===== tb/sv/tb_priority_ready_queue.sv =====
// Self-checking testbench for priority_ready_queue: activate and terminate words are
// driven on the input stream and every result word is compared with a local queue model.
// Depends on prq_pkg and the priority_ready_queue RTL.
module tb_priority_ready_queue;

  localparam int TASKS = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [3:0] head_task;
    logic       head_valid;
    logic [4:0] ready_count;
    logic [1:0] status;
  } queue_view_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = prq_pkg::OP_ACTIVATE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  logic [3:0] sched_task [TASKS];
  logic [7:0] sched_prio [TASKS];
  int         sched_len = 0;
  logic [7:0] act_count [TASKS];
  logic       task_ready [TASKS];

  queue_view_t pending_views [$];
  queue_view_t next_view;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  int error_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int deepest_queue = 0;
  int ok_seen = 0;
  int queued_seen = 0;
  int missing_seen = 0;

  priority_ready_queue #(.TASK_COUNT(TASKS)) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycle_count,
               pending_views.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    for (int i = 0; i < TASKS; i++) begin
      sched_task[i] = '0;
      sched_prio[i] = '0;
      act_count[i] = '0;
      task_ready[i] = 1'b0;
    end
  end

  function automatic void check_field(string name, int expv, int actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_views.size() == 0) begin
        $error("Result word %h arrived with nothing expected", m_tdata);
        error_count++;
      end else begin
        next_view = pending_views.pop_front();
        check_field("head_task", next_view.head_task, m_tdata[3:0]);
        check_field("head_valid", next_view.head_valid, m_tdata[4]);
        check_field("ready_count", next_view.ready_count, m_tdata[9:5]);
        check_field("status", next_view.status, m_tdata[11:10]);
        words_checked++;
      end
    end
  end

  function automatic queue_view_t apply_scheduler_op(logic op, logic [3:0] id,
                                                     logic [7:0] pri);
    queue_view_t view;
    int slot;
    int pos;
    int i;
    slot = -1;
    for (i = 0; i < sched_len; i++) begin
      if (sched_task[i] == id) slot = i;
    end
    if (op == prq_pkg::OP_ACTIVATE) begin
      if (act_count[id] != 8'hFF) act_count[id]++;
      task_ready[id] = 1'b1;
      if (slot >= 0 || sched_len >= TASKS) begin
        view.status = prq_pkg::STATUS_QUEUED;
      end else begin
        pos = sched_len;
        for (i = sched_len - 1; i >= 0; i--) begin
          if (pri > sched_prio[i]) pos = i;
        end
        for (i = sched_len; i > pos; i--) begin
          sched_task[i] = sched_task[i - 1];
          sched_prio[i] = sched_prio[i - 1];
        end
        sched_task[pos] = id;
        sched_prio[pos] = pri;
        sched_len++;
        view.status = prq_pkg::STATUS_OK;
      end
    end else begin
      task_ready[id] = 1'b0;
      if (act_count[id] != 8'h00) act_count[id]--;
      if (slot < 0) begin
        view.status = prq_pkg::STATUS_MISSING;
      end else begin
        for (i = slot; i < sched_len - 1; i++) begin
          sched_task[i] = sched_task[i + 1];
          sched_prio[i] = sched_prio[i + 1];
        end
        sched_len--;
        sched_task[sched_len] = '0;
        sched_prio[sched_len] = '0;
        view.status = prq_pkg::STATUS_OK;
      end
    end
    view.head_valid = (sched_len > 0);
    view.head_task = (sched_len > 0) ? sched_task[0] : 4'd0;
    view.ready_count = 5'(sched_len);
    return view;
  endfunction

  task automatic issue_scheduler_op(input logic op, input logic [3:0] id,
                                    input logic [7:0] pri);
    queue_view_t view;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'd0, pri, id};
    do @(posedge clk); while (!s_tready);
    view = apply_scheduler_op(op, id, pri);
    pending_views.push_back(view);
    words_sent++;
    if (sched_len > deepest_queue) deepest_queue = sched_len;
    case (view.status)
      prq_pkg::STATUS_OK:     ok_seen++;
      prq_pkg::STATUS_QUEUED: queued_seen++;
      default:                missing_seen++;
    endcase
  endtask

  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_priority();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(3) * 85);
      1:       return 8'($urandom_range(255));
      2:       return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(102, 100));
    endcase
  endfunction

  task automatic test_empty_queue_cases();
    issue_scheduler_op(prq_pkg::OP_TERMINATE, 4'd15, 8'hFF);
    issue_scheduler_op(prq_pkg::OP_ACTIVATE, 4'd0, 8'h00);
    issue_scheduler_op(prq_pkg::OP_TERMINATE, 4'd0, 8'h00);
    issue_scheduler_op(prq_pkg::OP_TERMINATE, 4'd0, 8'h5A);
  endtask

  task automatic test_priority_order();
    issue_scheduler_op(prq_pkg::OP_ACTIVATE, 4'd5, 8'd100);
    issue_scheduler_op(prq_pkg::OP_ACTIVATE, 4'd6, 8'd100);
    issue_scheduler_op(prq_pkg::OP_ACTIVATE, 4'd7, 8'd255);
    issue_scheduler_op(prq_pkg::OP_ACTIVATE, 4'd8, 8'd0);
    issue_scheduler_op(prq_pkg::OP_ACTIVATE, 4'd9, 8'd100);
    issue_scheduler_op(prq_pkg::OP_ACTIVATE, 4'd10, 8'd255);
    issue_scheduler_op(prq_pkg::OP_ACTIVATE, 4'd6, 8'd255);
    issue_scheduler_op(prq_pkg::OP_TERMINATE, 4'd7, 8'd0);
    issue_scheduler_op(prq_pkg::OP_TERMINATE, 4'd9, 8'd0);
    issue_scheduler_op(prq_pkg::OP_TERMINATE, 4'd8, 8'd0);
    issue_scheduler_op(prq_pkg::OP_TERMINATE, 4'd8, 8'd0);
    issue_scheduler_op(prq_pkg::OP_TERMINATE, 4'd10, 8'd0);
    issue_scheduler_op(prq_pkg::OP_TERMINATE, 4'd5, 8'd0);
    issue_scheduler_op(prq_pkg::OP_TERMINATE, 4'd6, 8'd0);
  endtask

  task automatic test_fill_and_drain();
    logic [3:0] order [TASKS];
    logic [3:0] tmp;
    int j;
    for (int i = 0; i < TASKS; i++) order[i] = 4'(i);
    for (int i = TASKS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < TASKS; i++) begin
      issue_scheduler_op(prq_pkg::OP_ACTIVATE, order[i], pick_priority());
    end
    issue_scheduler_op(prq_pkg::OP_ACTIVATE, 4'($urandom_range(15)), pick_priority());
    for (int i = 0; i < TASKS; i++) begin
      j = $urandom_range(i, TASKS - 1);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
      issue_scheduler_op(prq_pkg::OP_TERMINATE, order[i], 8'($urandom_range(255)));
    end
    issue_scheduler_op(prq_pkg::OP_TERMINATE, 4'($urandom_range(15)),
                       8'($urandom_range(255)));
  endtask

  task automatic test_random_schedule(input int count);
    logic [3:0] id;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 58) begin
        issue_scheduler_op(prq_pkg::OP_ACTIVATE, 4'($urandom_range(15)), pick_priority());
      end else begin
        if (sched_len > 0 && $urandom_range(99) < 80) begin
          id = sched_task[$urandom_range(sched_len - 1)];
        end else begin
          id = 4'($urandom_range(15));
        end
        issue_scheduler_op(prq_pkg::OP_TERMINATE, id, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    send_idle_pct = 15;
    recv_idle_pct = 84;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue_cases();
    test_priority_order();
    wait_until_drained();
    test_fill_and_drain();
    test_random_schedule(200);
    wait_until_drained();
    send_idle_pct = 84;
    recv_idle_pct = 15;
    test_fill_and_drain();
    test_random_schedule(200);
    wait_until_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_fill_and_drain();
    test_random_schedule(200);
    wait_until_drained();
    repeat (4) @(posedge clk);
    $display("Sent %0d words and checked %0d results; the queue reached %0d tasks.",
             words_sent, words_checked, deepest_queue);
    $display("Statuses seen: %0d ok, %0d already queued, %0d not queued.",
             ok_seen, queued_seen, missing_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/prq_pkg.sv
hdl/prq_cell.sv
hdl/priority_ready_queue.sv
tb/sv/tb_priority_ready_queue.sv
